// ----- rtl/mdx_track_stream_validator_top_assert.svh -----
// Assertion macros for the track stream validator.
// No dependencies; included by the top level only.
`ifndef MDX_TRACK_STREAM_VALIDATOR_TOP_ASSERT_SVH
`define MDX_TRACK_STREAM_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MDX_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("track validator assertion failed");

// Next-cycle implication, checked out of reset.
`define MDX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("track validator assertion failed");

`endif

// ----- rtl/mdxtsv_pkg.sv -----
// Shared constants, codes and opcode decode for the track stream validator.
// No dependencies.
package mdxtsv_pkg;

    localparam int INSTR_LIMIT = 32768;
    localparam int TRACK_COUNT = 16;

    localparam int IDX_W  = 2;
    localparam int CFG_W  = 24;
    localparam int OFS_W  = 24;
    localparam int FOFS_W = 25;
    localparam int CNT_W  = 16;
    localparam int OUT_W  = 80;

    // request kinds on tuser
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_DATA  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_MAX_INSTR = 2'd0;
    localparam logic [IDX_W-1:0] REG_BASE      = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHANNEL   = 2'd2;
    localparam logic [IDX_W-1:0] REG_PCM       = 2'd3;

    // verdict codes
    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_TRUNC  = 4'd1;
    localparam logic [3:0] ST_REPEAT = 4'd2;
    localparam logic [3:0] ST_SYNC   = 4'd3;
    localparam logic [3:0] ST_OPCODE = 4'd4;
    localparam logic [3:0] ST_PCM    = 4'd5;
    localparam logic [3:0] ST_EXT    = 4'd6;
    localparam logic [3:0] ST_BUDGET = 4'd7;
    localparam logic [3:0] ST_LIMITS = 4'd8;

    localparam logic [7:0] OP_REST_MAX = 8'h7f;
    localparam logic [7:0] OP_NOTE_MAX = 8'hdf;
    localparam logic [7:0] OP_EXT_MAX  = 8'he7;
    localparam logic [7:0] OP_PCM8     = 8'he8;
    localparam logic [7:0] OP_SYNC     = 8'hef;
    localparam logic [7:0] OP_LOOP_END = 8'hf1;
    localparam logic [7:0] OP_REPEAT   = 8'hf6;

    typedef struct packed {
        logic [1:0] len;
        logic [3:0] err;
    } op_dec_t;

    // Command length from its first byte, or a fault code with length zero.
    function automatic op_dec_t op_decode(logic [7:0] op);
        op_dec_t d;
        d.len = 2'd0;
        d.err = ST_OK;
        if (op <= OP_REST_MAX) begin
            d.len = 2'd1;
        end else if (op <= OP_NOTE_MAX) begin
            d.len = 2'd2;
        end else begin
            unique case (op)
                8'hff, 8'hfd, 8'hfc, 8'hfb, 8'hf8, 8'hf1, 8'hf0, 8'hef: d.len = 2'd2;
                8'hfe, 8'hf6, 8'hf5, 8'hf4, 8'hf3, 8'hf2:               d.len = 2'd3;
                8'hf7, 8'hee:                                           d.len = 2'd1;
                OP_PCM8:                                                d.err = ST_PCM;
                default: d.err = (op <= OP_EXT_MAX) ? ST_EXT : ST_OPCODE;
            endcase
        end
        return d;
    endfunction

endpackage

// ----- rtl/mdx_track_stream_validator_top.sv -----
// Track stream validator: byte-serial command parser with one verdict per track.
// Depends on mdxtsv_pkg and mdx_track_stream_validator_top_assert.svh.
// Usage
//   s_ channel: one request per byte. s_tuser holds the kind (start track, data
//   byte, end of data); s_tdata holds the track byte. A start request arms the
//   parser and checks the instruction limit; data bytes are grouped into
//   commands; the end command or the first fault gives the verdict.
//   m_ channel: one verdict request per track, packed in m_tdata.
//   cfg_ channel: register writes, index and data; always ready. Write only
//   while no track request is in flight.
// Timing: a request is registered at acceptance and judged once the output
//   register can take a verdict, and its verdict loads the output register,
//   which drives m_tvalid.
// Throughput: one request per cycle while no verdict waits on m_tready, set by
//   the single judging stage that updates the parser state once per byte.
// Stall: while a verdict waits on m_tready, one more request is taken into the
//   input register; s_tready then drops until the verdict is taken.
// Reset (aresetn low, synchronous): registers return to defaults, the parser
//   is idle until a start request, and both channels are empty.
`include "mdx_track_stream_validator_top_assert.svh"

module mdx_track_stream_validator_top #(
    parameter int MAX_CMDS   = mdxtsv_pkg::INSTR_LIMIT,
    parameter int NUM_TRACKS = mdxtsv_pkg::TRACK_COUNT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input requests
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic [1:0]                  s_tuser,   // [1:0] func
    // verdicts
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [3:0] status, [28:4] fault_ofs, [32:29] channel_out,
    // [48:33] cmd_total, [73:49] terminal_offset, [79:74] zero
    output logic [mdxtsv_pkg::OUT_W-1:0] m_tdata,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mdxtsv_pkg::IDX_W-1:0] cfg_index,
    input  logic [mdxtsv_pkg::CFG_W-1:0] cfg_data
);
    import mdxtsv_pkg::*;

    // configuration registers
    logic [CNT_W-1:0] max_instr_reg;
    logic [OFS_W-1:0] base_reg;
    logic [3:0]       channel_reg;
    logic             pcm_reg;

    // input register
    logic             in_valid_reg;
    logic [1:0]       in_func_reg;
    logic [7:0]       in_byte_reg;

    // parser state
    logic [OFS_W-1:0] cursor_reg, cursor_next;
    logic [OFS_W-1:0] istart_reg, istart_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       op_reg, op_next;
    logic [7:0]       second_reg, second_next;
    logic [1:0]       seen_reg, seen_next;
    logic [1:0]       need_reg, need_next;
    logic             finished_reg, finished_next;

    // output register
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;

    logic              advance;
    logic              res_valid;
    logic              res_fail;
    logic [3:0]        fail_code;
    logic [OFS_W-1:0]  fail_rel;
    logic [3:0]        res_status;
    logic [FOFS_W-1:0] res_offset;
    logic [CNT_W-1:0]  res_count;
    logic [FOFS_W-1:0] res_term;
    op_dec_t           dec;

    // Judge the held request when the output register can take a verdict.
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign dec       = op_decode(in_byte_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_instr_reg <= CNT_W'(MAX_CMDS);
            base_reg      <= '0;
            channel_reg   <= '0;
            pcm_reg       <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAX_INSTR: max_instr_reg <= cfg_data[CNT_W-1:0];
                REG_BASE:      base_reg      <= cfg_data[OFS_W-1:0];
                REG_CHANNEL:   channel_reg   <= cfg_data[3:0];
                REG_PCM:       pcm_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Capture a request; hold it until judged.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_comb begin
        cursor_next   = cursor_reg;
        istart_next   = istart_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        second_next   = second_reg;
        seen_next     = seen_reg;
        need_next     = need_reg;
        finished_next = finished_reg;
        res_valid     = 1'b0;
        res_fail      = 1'b0;
        fail_code     = ST_OK;
        fail_rel      = '0;

        if (advance) begin
            unique case (in_func_reg)
                FUNC_START: begin
                    cursor_next   = '0;
                    istart_next   = '0;
                    count_next    = '0;
                    op_next       = '0;
                    second_next   = '0;
                    seen_next     = '0;
                    need_next     = '0;
                    finished_next = 1'b0;
                    if (max_instr_reg == '0 ||
                        max_instr_reg > CNT_W'(MAX_CMDS)) begin
                        res_fail  = 1'b1;
                        fail_code = ST_LIMITS;
                    end
                end
                FUNC_END: begin
                    if (!finished_reg) begin
                        res_fail  = 1'b1;
                        fail_code = ST_TRUNC;
                        fail_rel  = (seen_reg != 2'd0) ? istart_reg : cursor_reg;
                    end
                end
                FUNC_DATA: begin
                    if (!finished_reg) begin
                        // Step one byte into the current command.
                        unique case (seen_reg)
                            2'd0: begin
                                if (count_reg == max_instr_reg) begin
                                    res_fail  = 1'b1;
                                    fail_code = ST_BUDGET;
                                    fail_rel  = cursor_reg;
                                end else if (dec.err != ST_OK) begin
                                    res_fail  = 1'b1;
                                    fail_code = dec.err;
                                    fail_rel  = cursor_reg;
                                end else begin
                                    istart_next = cursor_reg;
                                    op_next     = in_byte_reg;
                                    second_next = '0;
                                    need_next   = dec.len;
                                    seen_next   = 2'd1;
                                end
                            end
                            2'd1: begin
                                second_next = in_byte_reg;
                                if (op_reg == OP_LOOP_END && in_byte_reg != 8'd0) begin
                                    need_next = 2'd3;
                                end
                                if (op_reg == OP_SYNC && in_byte_reg >= 8'(NUM_TRACKS)) begin
                                    res_fail  = 1'b1;
                                    fail_code = ST_SYNC;
                                    fail_rel  = istart_reg;
                                end
                                seen_next = 2'd2;
                            end
                            default: begin
                                if (op_reg == OP_REPEAT && in_byte_reg != 8'd0) begin
                                    res_fail  = 1'b1;
                                    fail_code = ST_REPEAT;
                                    fail_rel  = istart_reg;
                                end
                                seen_next = 2'd3;
                            end
                        endcase

                        if (!res_fail) begin
                            cursor_next = cursor_reg + OFS_W'(1);
                            // Close the command once all its bytes are in.
                            if (seen_next >= need_next) begin
                                if (pcm_reg && !(op_next <= OP_REST_MAX) &&
                                    !(op_next == OP_LOOP_END && second_next == 8'd0 &&
                                      need_next == 2'd2)) begin
                                    res_fail  = 1'b1;
                                    fail_code = ST_PCM;
                                    fail_rel  = istart_next;
                                end else begin
                                    count_next = count_reg + CNT_W'(1);
                                    seen_next  = 2'd0;
                                    if (op_next == OP_LOOP_END && second_next == 8'd0 &&
                                        need_next == 2'd2) begin
                                        res_valid     = 1'b1;
                                        finished_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (res_fail) begin
                res_valid     = 1'b1;
                finished_next = 1'b1;
            end
        end
    end

    // Fold faults of a PCM track into the PCM code, except truncation,
    // budget and limits.
    always_comb begin
        res_status = ST_OK;
        res_offset = '0;
        res_count  = count_next;
        res_term   = {1'b0, base_reg} + {1'b0, istart_next};
        if (res_fail) begin
            res_status = fail_code;
            if (pcm_reg && fail_code != ST_TRUNC && fail_code != ST_BUDGET &&
                fail_code != ST_LIMITS) begin
                res_status = ST_PCM;
            end
            res_offset = {1'b0, base_reg} + {1'b0, fail_rel};
            res_count  = '0;
            res_term   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg   <= '0;
            istart_reg   <= '0;
            count_reg    <= '0;
            op_reg       <= '0;
            second_reg   <= '0;
            seen_reg     <= '0;
            need_reg     <= '0;
            finished_reg <= 1'b1;
        end else begin
            cursor_reg   <= cursor_next;
            istart_reg   <= istart_next;
            count_reg    <= count_next;
            op_reg       <= op_next;
            second_reg   <= second_next;
            seen_reg     <= seen_next;
            need_reg     <= need_next;
            finished_reg <= finished_next;
        end
    end

    // Verdict register: load on a verdict, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= {6'd0, res_term, res_count, channel_reg, res_offset, res_status};
        end
    end

    `MDX_ASSERT_IMPLY(a_ok_has_count, aclk, aresetn,
        m_tvalid && m_tdata[3:0] == ST_OK, m_tdata[48:33] != '0)
    `MDX_ASSERT_IMPLY(a_stall_only_when_full, aclk, aresetn,
        !s_tready, in_valid_reg && m_valid_reg && !m_tready)
    `MDX_ASSERT_NEXT(a_verdict_lands, aclk, aresetn,
        res_valid, m_tvalid && finished_reg)
endmodule
